FILE: rtl/hbse_pkg.sv
// ============================================================================
// hbse_pkg
// Shared types and constants of the switched hydrogen-bond energy pipeline.
// ============================================================================
package hbse_pkg;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS_ON  = 2'd0,
        CFG_RADIUS_OFF = 2'd1,
        CFG_ANGLE_ON   = 2'd2,
        CFG_ANGLE_OFF  = 2'd3
    } t_cfg_idx;

    // register reset values
    localparam logic [15:0] RST_RADIUS_ON  = 16'd18432;
    localparam logic [15:0] RST_RADIUS_OFF = 16'd22528;
    localparam logic [14:0] RST_ANGLE_ON   = 15'd8192;
    localparam logic [14:0] RST_ANGLE_OFF  = 15'd12288;

    // fixed-point constants
    localparam logic [16:0] ONE16   = 17'h1_0000;
    localparam logic [11:0] COEF_R6 = 12'd3855;
    localparam logic [9:0]  COEF_R4 = 10'd738;
    localparam logic [60:0] BCAP    = 61'h1000_0000_0000_0000;
    localparam logic [32:0] MCAP    = 33'h1_0000_0000;
    localparam logic [31:0] E_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] E_MIN   = 32'h8000_0000;

    // one input item
    typedef struct packed {
        logic        [15:0] distance;
        logic signed [15:0] cosine;
    } t_in;

    // one result item
    typedef struct packed {
        logic signed [31:0] energy;
        logic               saturated;
    } t_out;

    // per-item control flags carried down the pipeline
    typedef struct packed {
        logic dz;       // distance is zero
        logic ds;       // distance so short that the radial term is capped
        logic band_r;   // inside radial switching band
        logic below_r;  // below radial switching band
        logic band_a;   // inside angular band, angle switch negative
        logic above_a;  // above angular band
        logic kneg;     // radial bracket negative
        logic fnz;      // angular and switching factor nonzero
    } t_flags;

endpackage

FILE: rtl/hbond_switched_energy_top.sv
// ============================================================================
// hbond_switched_energy_top
// Pipeline: 25 register stages; an item is loaded into stage 1 at its accepting
// edge and reaches the output register at stage 25.
// Throughput: one item per cycle; the whole pipeline advances in step and
// holds only while the output register keeps a result that is stalled.
// Depth is set by the 48-bit reciprocal divider and the split wide multipliers.
// Reset clears valid bits and loads the register reset values; no clearing pass.
// ============================================================================
module hbond_switched_energy_top
    import hbse_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in                  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out                 o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int LAT = 25;

    // configuration registers
    logic [15:0] r_radius_on;
    logic [15:0] r_radius_off;
    logic [14:0] r_angle_on;
    logic [14:0] r_angle_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_on  <= RST_RADIUS_ON;
            r_radius_off <= RST_RADIUS_OFF;
            r_angle_on   <= RST_ANGLE_ON;
            r_angle_off  <= RST_ANGLE_OFF;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RADIUS_ON:  r_radius_on  <= i_cfg_data;
                CFG_RADIUS_OFF: r_radius_off <= i_cfg_data;
                CFG_ANGLE_ON:   r_angle_on   <= i_cfg_data[14:0];
                CFG_ANGLE_OFF:  r_angle_off  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // pipeline advance and valid bits
    logic adv;
    logic r_vld [1:LAT];

    assign adv     = !(r_vld[LAT] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[1] <= i_valid;
            for (int k = 2; k <= LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage 1: squares of distance, thresholds and cosine
    logic [15:0] n_cos;
    logic [15:0] n_cm;
    logic [31:0] n_c2;
    logic [31:0] r_x1;
    logic [31:0] r_xon1;
    logic [31:0] r_xoff1;
    logic [30:0] r_c2;
    logic [28:0] r_a0;
    logic [28:0] r_a1;

    assign n_cos = i_data.cosine;
    assign n_cm  = n_cos[15] ? 16'(~n_cos + 16'd1) : n_cos;
    assign n_c2  = 32'(n_cm) * 32'(n_cm);

    // stage 2: band decisions, sums and differences, cos^4
    logic [32:0] n_rn_sum;
    logic [32:0] n_rd_sum;
    logic [61:0] n_c2sq;
    logic [31:0] r_rn_a;
    logic [31:0] r_rn_b;
    logic [31:0] r_rd_a;
    logic [31:0] r_rd_b;
    logic [31:0] r_an_a;
    logic [31:0] r_an_b;
    logic [31:0] r_ad_a;
    logic [31:0] r_ad_b;
    logic [32:0] r_c4;

    assign n_rn_sum = {1'b0, r_xoff1} + {1'b0, r_x1};
    assign n_rd_sum = {1'b0, r_xoff1} + {1'b0, r_xon1};
    assign n_c2sq   = 62'(r_c2) * 62'(r_c2);

    // stage 3: numerators and denominators of both switch fractions
    logic [63:0] r_rnum;
    logic [63:0] r_rden;
    logic [63:0] r_anum;
    logic [63:0] r_aden;

    // stages 4..11: fraction dividers, 12..13: smoothstep
    logic [15:0] w_qr;
    logic [15:0] w_qa;
    logic        w_ger;
    logic        w_gea;
    logic [16:0] n_tr;
    logic [16:0] n_ta;
    logic [16:0] w_sr_s;
    logic [16:0] w_sa_s;

    hbse_div #(.DW(64), .QW(16), .SPS(2)) u_div_r (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_rnum),
        .i_den (r_rden),
        .o_quo (w_qr),
        .o_ge  (w_ger)
    );

    hbse_div #(.DW(64), .QW(16), .SPS(2)) u_div_a (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_anum),
        .i_den (r_aden),
        .o_quo (w_qa),
        .o_ge  (w_gea)
    );

    assign n_tr = w_ger ? ONE16 : {1'b0, w_qr};
    assign n_ta = w_gea ? ONE16 : {1'b0, w_qa};

    hbse_smooth u_sm_r (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_t   (n_tr),
        .o_s   (w_sr_s)
    );

    hbse_smooth u_sm_a (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_t   (n_ta),
        .o_s   (w_sa_s)
    );

    // cos^4 carried to stage 13
    logic [32:0] w_c4d;

    hbse_delay #(.W(33), .N(11)) u_dly_c4 (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_d   (r_c4),
        .o_d   (w_c4d)
    );

    // stages 2..13: reciprocal 2^56 / x, 48 quotient bits
    logic [47:0] w_u;

    hbse_div #(.DW(32), .QW(48), .SPS(4)) u_div_u (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (32'd256),
        .i_den (r_x1),
        .o_quo (w_u),
        .o_ge  ()
    );

    // control flags per stage
    t_flags r_flg [1:LAT-1];
    t_flags n_flg1;
    t_flags n_flg2;
    t_flags n_flg15;
    t_flags n_flg20;

    always_comb begin
        n_flg1    = '0;
        n_flg1.dz = (i_data.distance == 16'd0);
        n_flg1.ds = (i_data.distance <= 16'd16);
    end

    always_comb begin
        n_flg2         = r_flg[1];
        n_flg2.band_r  = (r_xon1 < r_x1) && (r_x1 < r_xoff1);
        n_flg2.below_r = (r_x1 < r_xon1);
        n_flg2.band_a  = ({3'b0, r_a0} < {1'b0, r_c2}) && ({1'b0, r_c2} < {3'b0, r_a1});
        n_flg2.above_a = ({1'b0, r_c2} > {3'b0, r_a1});
    end

    // stage 14: radial switch times cos^4; 3855 * u
    logic [16:0] n_sr;
    logic [49:0] n_f1p;
    logic [32:0] r_f1;
    logic [16:0] r_sa14;
    logic [59:0] r_ct14;

    always_comb begin
        priority if (r_flg[13].band_r) begin
            n_sr = w_sr_s;
        end else if (r_flg[13].below_r) begin
            n_sr = ONE16;
        end else begin
            n_sr = '0;
        end
    end

    assign n_f1p = 50'(w_c4d) * 50'(n_sr);

    // stage 15: angular switch; radial bracket magnitude and sign
    logic [16:0] n_sa;
    logic [49:0] n_fp;
    logic [59:0] n_dt;
    logic        n_kneg;
    logic        n_fnz;
    logic [32:0] r_f15;
    logic [59:0] r_km15;

    always_comb begin
        priority if (r_flg[14].band_a) begin
            n_sa = r_sa14;
        end else if (r_flg[14].above_a) begin
            n_sa = ONE16;
        end else begin
            n_sa = '0;
        end
    end

    assign n_fp   = 50'(r_f1) * 50'(n_sa);
    assign n_fnz  = (n_fp[48:16] != 33'd0);
    assign n_dt   = 60'(COEF_R4) << 32;
    assign n_kneg = (r_ct14 < n_dt);

    // stages 14..16: u^2
    logic [95:0] w_uu;
    logic [59:0] r_km16;

    hbse_mul #(.AW(48), .BW(48)) u_mul_uu (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (w_u),
        .i_b   (w_u),
        .o_p   (w_uu)
    );

    // stages 17..19: u^2 times bracket
    logic [123:0] w_bk;

    hbse_mul #(.AW(64), .BW(60)) u_mul_bk (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (w_uu[95:32]),
        .i_b   (r_km16),
        .o_p   (w_bk)
    );

    // stage 20: radial term, capped
    logic [75:0] n_bq;
    logic [60:0] n_bm;
    logic [60:0] r_bm;
    logic [32:0] w_f20;

    assign n_bq = w_bk[123:48];

    always_comb begin
        priority if (r_flg[19].ds) begin
            n_bm = BCAP;
        end else if (n_bq > 76'(BCAP)) begin
            n_bm = BCAP;
        end else begin
            n_bm = n_bq[60:0];
        end
    end

    hbse_delay #(.W(33), .N(5)) u_dly_f (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_d   (r_f15),
        .o_d   (w_f20)
    );

    // stages 21..23: radial term times angular factor
    logic [93:0] w_bf;

    hbse_mul #(.AW(61), .BW(33)) u_mul_bf (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (r_bm),
        .i_b   (w_f20),
        .o_p   (w_bf)
    );

    // stage 24: energy magnitude, capped
    logic [65:0] n_mq;
    logic [32:0] r_m;

    assign n_mq = w_bf[93:28];

    // stage 25: sign and saturation into the output register
    logic n_neg;
    t_out n_out;
    t_out r_out;

    always_comb begin
        n_neg           = r_flg[LAT-1].kneg ^ ((r_m != 33'd0) && r_flg[LAT-1].band_a);
        n_out.energy    = '0;
        n_out.saturated = 1'b0;
        priority if (r_flg[LAT-1].dz) begin
            n_out.saturated = 1'b1;
            if (r_flg[LAT-1].fnz) begin
                n_out.energy = r_flg[LAT-1].band_a ? E_MIN : E_MAX;
            end
        end else if (!n_neg) begin
            if (r_m > 33'(E_MAX)) begin
                n_out.energy    = E_MAX;
                n_out.saturated = 1'b1;
            end else begin
                n_out.energy = r_m[31:0];
            end
        end else begin
            if (r_m > 33'(E_MIN)) begin
                n_out.energy    = E_MIN;
                n_out.saturated = 1'b1;
            end else begin
                n_out.energy = ~r_m[31:0] + 32'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // stage 1
            r_x1    <= 32'(i_data.distance) * 32'(i_data.distance);
            r_xon1  <= 32'(r_radius_on) * 32'(r_radius_on);
            r_xoff1 <= 32'(r_radius_off) * 32'(r_radius_off);
            r_c2    <= n_c2[30:0];
            r_a0    <= {r_angle_on, 14'd0};
            r_a1    <= {r_angle_off, 14'd0};
            // stage 2
            r_rn_a  <= r_xoff1 - r_x1;
            r_rn_b  <= n_rn_sum[32:1];
            r_rd_a  <= r_xoff1 - r_xon1;
            r_rd_b  <= n_rd_sum[32:1];
            r_an_a  <= {1'b0, r_c2} - {3'b0, r_a0};
            r_an_b  <= {1'b0, r_c2} + {3'b0, r_a0};
            r_ad_a  <= {3'b0, r_a1} - {3'b0, r_a0};
            r_ad_b  <= {3'b0, r_a1} + {3'b0, r_a0};
            r_c4    <= n_c2sq[60:28];
            // stage 3
            r_rnum  <= 64'(r_rn_a) * 64'(r_rn_b);
            r_rden  <= 64'(r_rd_a) * 64'(r_rd_b);
            r_anum  <= 64'(r_an_a) * 64'(r_an_b);
            r_aden  <= 64'(r_ad_a) * 64'(r_ad_b);
            // stage 14
            r_f1    <= n_f1p[48:16];
            r_sa14  <= w_sa_s;
            r_ct14  <= 60'(w_u) * 60'(COEF_R6);
            // stage 15
            r_f15   <= n_fp[48:16];
            r_km15  <= n_kneg ? (n_dt - r_ct14) : (r_ct14 - n_dt);
            // stage 16
            r_km16  <= r_km15;
            // stage 20
            r_bm    <= n_bm;
            // stage 24
            r_m     <= (n_mq > 66'(MCAP)) ? MCAP : n_mq[32:0];
            // stage 25
            r_out   <= n_out;
        end
    end

    // bracket sign and nonzero factor join at stage 15
    always_comb begin
        n_flg15      = r_flg[14];
        n_flg15.kneg = n_kneg;
        n_flg15.fnz  = n_fnz;
    end

    // capped short distances give a positive radial term
    always_comb begin
        n_flg20      = r_flg[19];
        n_flg20.kneg = r_flg[19].kneg & ~r_flg[19].ds;
    end

    // flags travel with the item
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_flg[1] <= n_flg1;
            r_flg[2] <= n_flg2;
            for (int k = 3; k < LAT; k++) begin
                if (k == 15) begin
                    r_flg[k] <= n_flg15;
                end else if (k == 20) begin
                    r_flg[k] <= n_flg20;
                end else begin
                    r_flg[k] <= r_flg[k-1];
                end
            end
        end
    end

    assign o_data = r_out;

endmodule

FILE: rtl/hbse_delay.sv
// ============================================================================
// hbse_delay
// Enabled shift line that carries a side value along the pipeline.
// ============================================================================
module hbse_delay
    import hbse_pkg::*;
#(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_line [N];

    // shift when the pipeline advances
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_d = r_line[N-1];

endmodule

FILE: rtl/hbse_div.sv
// ============================================================================
// hbse_div
// Pipelined restoring divider: floor(2^QW * num / den) for num < den,
// SPS quotient bits per stage, plus a flag for num >= den.
// ============================================================================
module hbse_div
    import hbse_pkg::*;
#(
    parameter int DW  = 32,
    parameter int QW  = 16,
    parameter int SPS = 2
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_ge
);

    localparam int NST = QW / SPS;

    logic [DW-1:0] in_rem [NST];
    logic [DW-1:0] in_den [NST];
    logic [QW-1:0] in_quo [NST];
    logic          in_ge  [NST];
    logic [DW-1:0] n_rem  [NST];
    logic [QW-1:0] n_quo  [NST];
    logic [DW-1:0] r_rem  [NST];
    logic [DW-1:0] r_den  [NST];
    logic [QW-1:0] r_quo  [NST];
    logic          r_ge   [NST];

    for (genvar g = 0; g < NST; g++) begin : g_stage
        // stage inputs
        if (g == 0) begin : g_first
            assign in_rem[g] = i_num;
            assign in_den[g] = i_den;
            assign in_quo[g] = '0;
            assign in_ge[g]  = (i_num >= i_den);
        end else begin : g_next
            assign in_rem[g] = r_rem[g-1];
            assign in_den[g] = r_den[g-1];
            assign in_quo[g] = r_quo[g-1];
            assign in_ge[g]  = r_ge[g-1];
        end

        // SPS shift-subtract steps
        always_comb begin : c_step
            logic [DW-1:0] rem;
            logic [DW:0]   dbl;
            logic [QW-1:0] quo;
            rem = in_rem[g];
            quo = in_quo[g];
            for (int s = 0; s < SPS; s++) begin
                dbl = {rem, 1'b0};
                if (dbl >= {1'b0, in_den[g]}) begin
                    dbl = dbl - {1'b0, in_den[g]};
                    quo = {quo[QW-2:0], 1'b1};
                end else begin
                    quo = {quo[QW-2:0], 1'b0};
                end
                rem = dbl[DW-1:0];
            end
            n_rem[g] = rem;
            n_quo[g] = quo;
        end

        // stage register
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem[g];
                r_den[g] <= in_den[g];
                r_quo[g] <= n_quo[g];
                r_ge[g]  <= in_ge[g];
            end
        end
    end

    assign o_quo = r_quo[NST-1];
    assign o_ge  = r_ge[NST-1];

endmodule

FILE: rtl/hbse_mul.sv
// ============================================================================
// hbse_mul
// Wide unsigned multiplier split into four partial products, three stages.
// ============================================================================
module hbse_mul
    import hbse_pkg::*;
#(
    parameter int AW = 48,
    parameter int BW = 48
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] r_p00;
    logic [AL+BH-1:0] r_p01;
    logic [AH+BL-1:0] r_p10;
    logic [AH+BH-1:0] r_p11;
    logic [PW-1:0]    r_s0;
    logic [PW-1:0]    r_s1;
    logic [PW-1:0]    r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // partial products
            r_p00 <= (AL+BL)'(i_a[AL-1:0])  * (AL+BL)'(i_b[BL-1:0]);
            r_p01 <= (AL+BH)'(i_a[AL-1:0])  * (AL+BH)'(i_b[BW-1:BL]);
            r_p10 <= (AH+BL)'(i_a[AW-1:AL]) * (AH+BL)'(i_b[BL-1:0]);
            r_p11 <= (AH+BH)'(i_a[AW-1:AL]) * (AH+BH)'(i_b[BW-1:BL]);
            // pairwise sums
            r_s0  <= PW'(r_p00) + (PW'(r_p01) << BL);
            r_s1  <= (PW'(r_p10) << AL) + (PW'(r_p11) << (AL + BL));
            // final sum
            r_p   <= r_s0 + r_s1;
        end
    end

    assign o_p = r_p;

endmodule

FILE: rtl/hbse_smooth.sv
// ============================================================================
// hbse_smooth
// Two-stage smoothstep s(t) = t^2 (3 - 2t) in Q1.16.
// ============================================================================
module hbse_smooth
    import hbse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [16:0] i_t,
    output logic [16:0] o_s
);

    localparam logic [17:0] THREE_ONE = 18'(3 * ONE16);

    logic [33:0] n_tt;
    logic [34:0] n_pp;
    logic [16:0] r_t2;
    logic [17:0] r_m;
    logic [16:0] r_s;

    assign n_tt = 34'(i_t) * 34'(i_t);
    assign n_pp = 35'(r_t2) * 35'(r_m);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // t^2 and (3 - 2t)
            r_t2 <= n_tt[32:16];
            r_m  <= THREE_ONE - {i_t, 1'b0};
            // product
            r_s  <= n_pp[32:16];
        end
    end

    assign o_s = r_s;

endmodule

FILE: rtl/hbse_checker.sv
// ============================================================================
// hbse_checker
// Port-level checks of the switched hydrogen-bond energy block.
// ============================================================================
module hbse_checker
    import hbse_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    // input side holds only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

    // a nonzero saturated energy sits at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.saturated && (o_data.energy != 32'sd0))
        |-> ((o_data.energy == E_MAX) || (o_data.energy == E_MIN)))
        else $error("saturated energy not at a limit");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind hbond_switched_energy_top hbse_checker u_hbse_checker (.*);

FILE: tb/hbond_switched_energy_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// hbond_switched_energy_top_tb
// Self-checking bench for the switched hydrogen-bond energy pipeline. A
// predictor in the bench recomputes each donor-acceptor energy and compares
// it with the result stream. The bench uses directed edge cases, then
// randomized phases under several register settings, random stalls on both
// sides, one long output hold-off and one drain pause.
// ============================================================================
module hbond_switched_energy_top_tb
    import hbse_pkg::*;
();

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    t_in                  i_data = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_out                 o_data;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    hbond_switched_energy_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [15:0] cur_radius_on  = RST_RADIUS_ON;
    logic [15:0] cur_radius_off = RST_RADIUS_OFF;
    logic [14:0] cur_angle_on   = RST_ANGLE_ON;
    logic [14:0] cur_angle_off  = RST_ANGLE_OFF;

    t_out energy_expected[$];
    int   mismatch_count = 0;
    int   pairs_sent = 0;
    int   energies_checked = 0;
    int   settings_used = 0;
    bit   idling_on = 1'b1;
    int   hold_left = 0;
    int   out_gap_left = 0;

    // floor(2^16 * num / den), limited to one
    function automatic logic [63:0] ratio16(logic [63:0] num, logic [63:0] den);
        logic [127:0] w;
        if (num >= den) return 64'(ONE16);
        w = {64'd0, num} << 16;
        return 64'(w / {64'd0, den});
    endfunction

    function automatic logic [63:0] smoothstep16(logic [63:0] t);
        logic [63:0] t2;
        t2 = (t * t) >> 16;
        return (t2 * (64'd196608 - 2 * t)) >> 16;
    endfunction

    // floor(a*b / 2^sh), limited to lim
    function automatic logic [63:0] mul_shift_cap(logic [63:0] a, logic [63:0] b,
                                                  int sh, logic [63:0] lim);
        logic [127:0] w;
        w = ({64'd0, a} * {64'd0, b}) >> sh;
        return (w > {64'd0, lim}) ? lim : w[63:0];
    endfunction

    function automatic t_out predict_energy(t_in item);
        logic [63:0] d, cm, x, xon, xoff, c2, a0, a1;
        logic [63:0] sr, samag, f, u, u2, km, bm, m, ct, dt, e;
        logic        sa_neg, neg, flag;
        t_out        r;
        d     = {48'd0, item.distance};
        cm    = item.cosine[15] ? 64'h10000 - {48'd0, item.cosine} : {48'd0, item.cosine};
        x     = d * d;
        xon   = {48'd0, cur_radius_on} * {48'd0, cur_radius_on};
        xoff  = {48'd0, cur_radius_off} * {48'd0, cur_radius_off};
        c2    = cm * cm;
        a0    = {49'd0, cur_angle_on} << 14;
        a1    = {49'd0, cur_angle_off} << 14;
        samag = 0;
        sa_neg = 1'b0;
        e     = 0;
        flag  = 1'b0;
        // radial switch in the fourth power of distance
        if (xon < x && x < xoff)
            sr = smoothstep16(ratio16((xoff - x) * ((xoff + x) >> 1),
                                      (xoff - xon) * ((xoff + xon) >> 1)));
        else
            sr = (x < xon) ? 64'(ONE16) : 64'd0;
        // angular switch, negated inside the band
        if (a0 < c2 && c2 < a1) begin
            samag  = smoothstep16(ratio16((c2 - a0) * (c2 + a0), (a1 - a0) * (a1 + a0)));
            sa_neg = 1'b1;
        end else if (c2 > a1) begin
            samag = 64'(ONE16);
        end
        f = (((((c2 * c2) >> 28) * sr) >> 16) * samag) >> 16;
        if (d == 0) begin
            flag = 1'b1;
            if (f != 0) e = sa_neg ? 64'(E_MIN) : 64'(E_MAX);
        end else if (f != 0) begin
            neg = 1'b0;
            u = (64'd1 << 56) / x;
            if (u >= (64'd1 << 48)) begin
                bm = 64'(BCAP);
            end else begin
                u2 = mul_shift_cap(u, u, 32, '1);
                ct = 64'(COEF_R6) * u;
                dt = 64'(COEF_R4) << 32;
                if (ct >= dt) km = ct - dt;
                else begin
                    km  = dt - ct;
                    neg = 1'b1;
                end
                bm = mul_shift_cap(u2, km, 48, 64'(BCAP));
            end
            m = mul_shift_cap(bm, f, 28, 64'(MCAP));
            if (m != 0 && sa_neg) neg = !neg;
            if (!neg) begin
                if (m > 64'h7FFF_FFFF) begin
                    e = 64'(E_MAX);
                    flag = 1'b1;
                end else e = m;
            end else begin
                if (m > 64'h8000_0000) begin
                    e = 64'(E_MIN);
                    flag = 1'b1;
                end else e = (64'h1_0000_0000 - m) & 64'hFFFF_FFFF;
            end
        end
        r.energy    = e[31:0];
        r.saturated = flag;
        return r;
    endfunction

    // output side stall generator, long hold-off has priority
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (out_gap_left > 0) begin
            out_gap_left <= out_gap_left - 1;
            i_stall <= 1'b1;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            out_gap_left <= $urandom_range(0, 4);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (energy_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: energy %h saturated %b",
                             o_data.energy, o_data.saturated);
            end else begin
                want = energy_expected.pop_front();
                energies_checked++;
                if (o_data.energy !== want.energy || o_data.saturated !== want.saturated) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: expected energy %h sat %b, got energy %h sat %b",
                                 energies_checked, want.energy, want.saturated,
                                 o_data.energy, o_data.saturated);
                end
            end
        end
    end

    // offer one pair and hold it until accepted; valid stays high afterwards
    task automatic send_pair(logic [15:0] pair_dist, logic [15:0] cosv);
        t_in item;
        int  gap;
        item.distance = pair_dist;
        item.cosine   = cosv;
        if (idling_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        energy_expected = {energy_expected, predict_energy(item)};
        pairs_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (energy_expected.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // write all four registers on consecutive edges, pipeline idle
    task automatic load_switch_regs(logic [15:0] r_on, logic [15:0] r_off,
                                    logic [14:0] a_on, logic [14:0] a_off);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_RADIUS_ON;
        i_cfg_data <= r_on;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RADIUS_OFF;
        i_cfg_data <= r_off;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ANGLE_ON;
        i_cfg_data <= {1'b0, a_on};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ANGLE_OFF;
        i_cfg_data <= {1'b0, a_off};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        cur_radius_on  = r_on;
        cur_radius_off = r_off;
        cur_angle_on   = a_on;
        cur_angle_off  = a_off;
        settings_used++;
    endtask

    // random pair, mostly physical distances and in-range cosines
    task automatic send_random_pair();
        logic [15:0] pair_dist, cosv;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) pair_dist = 16'($urandom_range(2048, 26000));
        else if (sel < 80) pair_dist = 16'($urandom_range(0, 64));
        else pair_dist = 16'($urandom_range(0, 65535));
        sel = $urandom_range(0, 99);
        if (sel < 80) cosv = 16'($urandom_range(0, 32768) - 16384);
        else if (sel < 92) cosv = 16'($urandom_range(0, 600) + 15784)
                                  * ($urandom_range(0, 1) ? 16'h0001 : 16'hFFFF);
        else cosv = 16'($urandom_range(0, 65535));
        send_pair(pair_dist, cosv);
    endtask

    task automatic test_directed_edges();
        send_pair(16'd0, 16'sd16384);          // zero distance, full angle
        send_pair(16'd0, 16'sd0);              // zero distance, no angle term
        send_pair(16'd0, 16'sd12000);          // zero distance inside angle band
        send_pair(16'd1, 16'sd16384);          // very short distance
        send_pair(16'd16, -16'sd16384);
        send_pair(16'd17, 16'sd16384);         // just past the short cap
        send_pair(16'd4096, 16'sd16384);       // one angstrom
        send_pair(16'd4096, -16'sd16384);
        send_pair(16'd11000, 16'sd16384);      // near the bracket sign change
        send_pair(16'd18432, 16'sd16384);      // on the inner radius edge
        send_pair(16'd18431, 16'sd16384);
        send_pair(16'd20000, 16'sd16384);      // inside radial band
        send_pair(16'd22528, 16'sd16384);      // on the cutoff
        send_pair(16'd65535, 16'sd16384);
        send_pair(16'd12000, 16'sd11585);      // cos^2 near angle_on
        send_pair(16'd12000, 16'sd13000);      // inside angle band
        send_pair(16'd12000, -16'sd14189);     // near angle_off
        send_pair(16'd12000, 16'sd0);
        send_pair(16'd12000, 16'h8000);        // cosine beyond -1
        send_pair(16'd12000, 16'h7FFF);        // cosine beyond +1
        send_pair(16'd2000, 16'h7FFF);         // large energy, clipping
        send_pair(16'd20000, 16'sd13000);      // both bands at once
        drain_results();
    endtask

    task automatic test_random_setting(logic [15:0] r_on, logic [15:0] r_off,
                                       logic [14:0] a_on, logic [14:0] a_off, int count);
        load_switch_regs(r_on, r_off, a_on, a_off);
        repeat (count) send_random_pair();
        drain_results();
    endtask

    task automatic test_output_holdoff();
        idling_on = 1'b0;
        hold_left = 300;
        repeat (120) send_random_pair();
        idling_on = 1'b1;
        drain_results();
    endtask

    task automatic test_sender_pause();
        repeat (50) send_random_pair();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (energy_expected.size() != 0) @(posedge i_clk);
        repeat (50) send_random_pair();
        drain_results();
    endtask

    task automatic test_no_idling();
        idling_on = 1'b0;
        repeat (150) send_random_pair();
        drain_results();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_random_setting(RST_RADIUS_ON, RST_RADIUS_OFF, RST_ANGLE_ON, RST_ANGLE_OFF, 150);
        test_random_setting(16'd0, 16'd65535, 15'd0, 15'd16384, 130);
        test_random_setting(16'd65535, 16'd0, 15'd16384, 15'd0, 100);
        test_random_setting(16'd65535, 16'd65535, 15'd32767, 15'd32767, 60);
        test_random_setting(16'd8192, 16'd24576, 15'd4000, 15'd15000, 130);
        test_random_setting(16'($urandom_range(4096, 20000)),
                            16'($urandom_range(16000, 30000)),
                            15'($urandom_range(0, 12000)),
                            15'($urandom_range(8000, 16384)), 100);
        test_output_holdoff();
        test_sender_pause();
        test_no_idling();
        $display("checked %0d energies from %0d pairs under %0d register settings,",
                 energies_checked, pairs_sent, settings_used + 1);
        $display("including band edges, zero and capped distances, clipping and stalls");
        if (mismatch_count == 0 && energy_expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("timeout with %0d results outstanding", energy_expected.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: hbond_switched_energy_top.f
rtl/hbse_pkg.sv
rtl/hbse_delay.sv
rtl/hbse_div.sv
rtl/hbse_mul.sv
rtl/hbse_smooth.sv
rtl/hbond_switched_energy_top.sv
rtl/hbse_checker.sv
tb/hbond_switched_energy_top_tb.sv
